// ----- sv/uer_pkg.sv -----
`timescale 1ns / 1ps
package uer_pkg;

    localparam int COUNTER_BITS_DEF = 24;
    localparam int MID_DEPTH_DEF    = 2;
    localparam int OUT_DEPTH_DEF    = 4;

    localparam int RES_W     = 24;
    localparam int WRAP_W    = 32;
    localparam int TRIG_W    = 16;
    localparam int SCALE_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    localparam logic [RES_W-1:0] MAX24 = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd2;

    localparam logic [TRIG_W-1:0]  TRIGGER_RST = 16'd80;
    localparam logic [RES_W-1:0]   TIMEOUT_RST = 24'd320000;
    localparam logic [SCALE_W-1:0] SCALE_RST   = 16'd17983;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_TRIG  = 4'b0010,
        PH_WAIT1 = 4'b0100,
        PH_WAIT2 = 4'b1000
    } t_phase;

    // per-item status handed from front to back
    typedef struct packed {
        logic trig;
        logic busy;
        logic done;
        logic tout;
        logic wrapped;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

endpackage

// ----- sv/uer_fifo.sv -----
`timescale 1ns / 1ps
module uer_fifo
    import uer_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end
endmodule

// ----- sv/uer_front.sv -----
`timescale 1ns / 1ps
module uer_front
    import uer_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic                    i_func,
    input  logic                    i_echo,
    input  logic [TRIG_W-1:0]       i_trigger_ticks,
    input  logic [RES_W-1:0]        i_timeout_ticks,
    output t_flags                  o_flags,
    output logic [COUNTER_BITS-1:0] o_pulse,
    output logic [WRAP_W-1:0]       o_wrap_total
);
    localparam int CB = COUNTER_BITS;

    t_phase            r_phase, n_phase;
    logic [CB-1:0]     r_counter, n_counter;
    logic [CB-1:0]     r_start, n_start;
    logic [RES_W-1:0]  r_ticks, n_ticks;
    logic [WRAP_W-1:0] r_wrap, n_wrap;
    logic              r_last_echo;
    logic [RES_W-1:0]  ticks_inc;
    logic              echo_edge;

    always_comb begin
        n_phase   = r_phase;
        n_counter = r_counter;
        n_start   = r_start;
        n_ticks   = r_ticks;
        n_wrap    = r_wrap;
        o_flags   = '0;
        o_pulse   = '0;
        echo_edge = i_echo ^ r_last_echo;
        ticks_inc = (r_phase != PH_IDLE && r_ticks != MAX24) ? r_ticks + RES_W'(1) : r_ticks;

        if (i_func) begin
            n_phase = PH_TRIG;
            n_ticks = '0;
        end else begin
            n_counter = r_counter - CB'(1);
            n_ticks   = ticks_inc;
            case (r_phase)
                PH_TRIG: begin
                    if (ticks_inc >= RES_W'(i_trigger_ticks)) begin
                        n_phase = PH_WAIT1;
                    end
                end
                PH_WAIT1: begin
                    if (echo_edge) begin
                        n_start = r_counter;
                        n_phase = PH_WAIT2;
                    end else if (ticks_inc >= i_timeout_ticks) begin
                        o_flags.tout = 1'b1;
                        n_phase      = PH_IDLE;
                    end
                end
                PH_WAIT2: begin
                    if (echo_edge) begin
                        // the echo edge in this phase closes the pulse; captured value is pre-decrement
                        o_pulse         = r_start - r_counter;
                        o_flags.wrapped = (r_start < r_counter);
                        if (r_start < r_counter) begin
                            n_wrap = r_wrap + WRAP_W'(1);
                        end
                        o_flags.done = 1'b1;
                        n_phase      = PH_IDLE;
                    end else if (ticks_inc >= i_timeout_ticks) begin
                        o_flags.tout = 1'b1;
                        n_phase      = PH_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end
        o_flags.trig = (n_phase == PH_TRIG);
        o_flags.busy = (n_phase != PH_IDLE);
        o_wrap_total = n_wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_counter   <= '1;
            r_start     <= '0;
            r_ticks     <= '0;
            r_wrap      <= '0;
            r_last_echo <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_counter   <= n_counter;
            r_start     <= n_start;
            r_ticks     <= n_ticks;
            r_wrap      <= n_wrap;
            r_last_echo <= i_echo;
        end
    end
endmodule

// ----- sv/uer_back.sv -----
`timescale 1ns / 1ps
module uer_back
    import uer_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_mid_empty,
    input  t_flags                  i_mid_flags,
    input  logic [COUNTER_BITS-1:0] i_mid_pulse,
    input  logic [WRAP_W-1:0]       i_mid_wrap,
    output logic                    o_mid_pop,
    input  logic [SCALE_W-1:0]      i_scale,
    input  logic                    i_out_full,
    output logic                    o_out_push,
    output t_flags                  o_out_flags,
    output logic [RES_W-1:0]        o_out_pulse,
    output logic [RES_W-1:0]        o_out_dist,
    output logic [WRAP_W-1:0]       o_out_wrap
);
    localparam int CB  = COUNTER_BITS;
    localparam int PRW = CB + SCALE_W;
    localparam int XW  = (CB > RES_W) ? CB : RES_W;

    logic              r_sv;
    t_flags            r_flags;
    logic [CB-1:0]     r_pulse;
    logic [WRAP_W-1:0] r_wrap;
    logic [PRW-1:0]    r_prod;
    logic              advance;
    logic [XW-1:0]     pulse_x, dist_x;

    assign advance    = !r_sv || !i_out_full;
    assign o_mid_pop  = advance && !i_mid_empty;
    assign o_out_push = r_sv && !i_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (advance) begin
            r_sv <= !i_mid_empty;
        end
    end

    // product registered before saturation
    always_ff @(posedge i_clk) begin
        if (o_mid_pop) begin
            r_flags <= i_mid_flags;
            r_pulse <= i_mid_pulse;
            r_wrap  <= i_mid_wrap;
            r_prod  <= PRW'(i_mid_pulse) * PRW'(i_scale);
        end
    end

    assign pulse_x     = XW'(r_pulse);
    assign dist_x      = XW'(r_prod[PRW-1:SCALE_W]);
    assign o_out_pulse = (pulse_x > XW'(MAX24)) ? MAX24 : pulse_x[RES_W-1:0];
    assign o_out_dist  = (dist_x > XW'(MAX24)) ? MAX24 : dist_x[RES_W-1:0];
    assign o_out_flags = r_flags;
    assign o_out_wrap  = r_wrap;
endmodule

// ----- sv/ultrasonic_echo_ranger.sv -----
`timescale 1ns / 1ps
// ping-echo ranger: start items raise the trigger, tick items run the echo timing
// throughput: one item per cycle while the middle queue has room; the front updates its state for each taken item
// path: an item's front update goes through the middle queue and the registered
// multiply stage into the output queue; queues let either side stall on its own
// reset (synchronous, active low): idle, counter all ones, registers at defaults
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF,
    parameter int MID_DEPTH    = MID_DEPTH_DEF,
    parameter int OUT_DEPTH    = OUT_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input queue side
    input  logic                 push,
    output logic                 full,
    input  logic                 i_func,
    input  logic                 i_echo,
    // result queue side
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_trigger_level,
    output logic                 o_busy_res,
    output logic                 o_done_res,
    output logic                 o_timed_out,
    output logic [RES_W-1:0]     o_pulse_ticks,
    output logic [RES_W-1:0]     o_distance_q8,
    output logic                 o_wrapped,
    output logic [WRAP_W-1:0]    o_wrap_total,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);
    localparam int MID_W = FLAGS_W + COUNTER_BITS + WRAP_W;
    localparam int OUT_W = FLAGS_W + RES_W + RES_W + WRAP_W;

    // configuration registers
    logic [TRIG_W-1:0]  r_trigger_ticks;
    logic [RES_W-1:0]   r_timeout_ticks;
    logic [SCALE_W-1:0] r_scale;
    logic               cfg_wr;

    // front to queue
    logic                    accept;
    t_flags                  front_flags;
    logic [COUNTER_BITS-1:0] front_pulse;
    logic [WRAP_W-1:0]       front_wrap;

    // queue to back
    logic                    mid_full, mid_empty, mid_pop;
    logic [MID_W-1:0]        mid_data;
    t_flags                  mid_flags;
    logic [COUNTER_BITS-1:0] mid_pulse;
    logic [WRAP_W-1:0]       mid_wrap;

    // back to result queue
    logic              out_full, out_push;
    t_flags            back_flags;
    logic [RES_W-1:0]  back_pulse, back_dist;
    logic [WRAP_W-1:0] back_wrap;
    logic [OUT_W-1:0]  out_data;
    t_flags            out_flags;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks <= TRIGGER_RST;
            r_timeout_ticks <= TIMEOUT_RST;
            r_scale         <= SCALE_RST;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_TRIGGER: r_trigger_ticks <= i_cfg_data[TRIG_W-1:0];
                CFG_TIMEOUT: r_timeout_ticks <= i_cfg_data[RES_W-1:0];
                CFG_SCALE:   r_scale         <= i_cfg_data[SCALE_W-1:0];
                default: begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    // an item is taken whenever the middle queue has room
    assign full   = mid_full;
    assign accept = push && !mid_full;

    uer_front #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_func         (i_func),
        .i_echo         (i_echo),
        .i_trigger_ticks(r_trigger_ticks),
        .i_timeout_ticks(r_timeout_ticks),
        .o_flags        (front_flags),
        .o_pulse        (front_pulse),
        .o_wrap_total   (front_wrap)
    );

    uer_fifo #(
        .WIDTH(MID_W),
        .DEPTH(MID_DEPTH)
    ) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_data ({front_flags, front_pulse, front_wrap}),
        .o_full (mid_full),
        .i_pop  (mid_pop),
        .o_data (mid_data),
        .o_empty(mid_empty)
    );

    assign {mid_flags, mid_pulse, mid_wrap} = mid_data;

    uer_back #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mid_empty(mid_empty),
        .i_mid_flags(mid_flags),
        .i_mid_pulse(mid_pulse),
        .i_mid_wrap (mid_wrap),
        .o_mid_pop  (mid_pop),
        .i_scale    (r_scale),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out_flags(back_flags),
        .o_out_pulse(back_pulse),
        .o_out_dist (back_dist),
        .o_out_wrap (back_wrap)
    );

    uer_fifo #(
        .WIDTH(OUT_W),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (out_push),
        .i_data ({back_flags, back_pulse, back_dist, back_wrap}),
        .o_full (out_full),
        .i_pop  (pop),
        .o_data (out_data),
        .o_empty(empty)
    );

    assign {out_flags, o_pulse_ticks, o_distance_q8, o_wrap_total} = out_data;
    assign o_trigger_level = out_flags.trig;
    assign o_busy_res      = out_flags.busy;
    assign o_done_res      = out_flags.done;
    assign o_timed_out     = out_flags.tout;
    assign o_wrapped       = out_flags.wrapped;

    // a start always leaves the front in the trigger phase with nothing finished
    a_start_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func) |-> (front_flags.trig && front_flags.busy
                                && !front_flags.done && !front_flags.tout))
        else $error("start item did not enter trigger phase");

    // a finished or abandoned measurement leaves the block idle
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_done_res || o_timed_out)) |-> (!o_busy_res && !o_trigger_level
                                                     && !(o_done_res && o_timed_out)))
        else $error("done or timeout with measurement still busy");

    // result fields stay zero unless a pulse was measured
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_done_res) |-> (o_pulse_ticks == '0 && o_distance_q8 == '0
                                     && !o_wrapped))
        else $error("pulse fields set without done");

    // the back stage only takes an item the queue actually holds
    a_mid_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_pop |-> !mid_empty)
        else $error("middle queue popped while empty");
endmodule
